// ----- hw/rtl/bmp_pixel_array_decoder_core_macros.svh -----
// Assertion macros shared by the decoder checkers.
`ifndef BMP_PIXEL_ARRAY_DECODER_CORE_MACROS_SVH
`define BMP_PIXEL_ARRAY_DECODER_CORE_MACROS_SVH

// same-cycle implication, masked while reset is high
`define BPD_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpd checker: implication failed");

// next-cycle implication, also checked through reset
`define BPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bpd checker: next-cycle check failed");

`endif

// ----- hw/rtl/bpd_pkg.sv -----
// Shared types, codes and defaults of the BMP pixel-array decoder.
package bpd_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int COORD_BITS_DEF    = 16;
  localparam int JOB_DEPTH         = 4;
  localparam int RES_DEPTH         = 4;

  // input actions
  localparam logic [1:0] ACT_PAL  = 2'd0;
  localparam logic [1:0] ACT_DATA = 2'd1;
  localparam logic [1:0] ACT_NEW  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_PCOUNT = 2'd3;

  // pixel modes
  localparam logic [2:0] MODE_RGB1  = 3'd0;
  localparam logic [2:0] MODE_RGB4  = 3'd1;
  localparam logic [2:0] MODE_RGB8  = 3'd2;
  localparam logic [2:0] MODE_RGB24 = 3'd3;
  localparam logic [2:0] MODE_RLE4  = 3'd4;
  localparam logic [2:0] MODE_RLE8  = 3'd5;

  typedef enum logic [7:0] {
    PH_FIRST  = 8'b0000_0001,
    PH_PAD    = 8'b0000_0010,
    PH_GREEN  = 8'b0000_0100,
    PH_RED    = 8'b0000_1000,
    PH_RUNVAL = 8'b0001_0000,
    PH_ESCAPE = 8'b0010_0000,
    PH_ABS    = 8'b0100_0000,
    PH_ABSPAD = 8'b1000_0000
  } bpd_phase_t;

  // how pixel indices are cut from a byte
  typedef enum logic [1:0] {
    BITS_1 = 2'd0,
    BITS_4 = 2'd1,
    BITS_8 = 2'd2
  } bpd_bits_t;

  // one job from front to back: a palette write or the results of one word
  typedef struct packed {
    logic        pal;
    logic [7:0]  byte_val;
    logic [23:0] color;
    bpd_bits_t   bits;
    logic [3:0]  npix;
    logic        direct;
    logic        run;
    logic        mark;
    logic [7:0]  idx1;
    logic [7:0]  idx2;
    logic        use2;
    logic [7:0]  rep;
    logic        alt;
    logic        re;
    logic        ie;
    logic        err;
  } bpd_job_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] second_red;
    logic [7:0] second_green;
    logic [7:0] second_blue;
    logic [7:0] repeat_count;
    logic       alternating;
    logic       row_end;
    logic       image_end;
    logic       error_flag;
    logic       last_for_byte;
  } bpd_res_t;

endpackage

// ----- hw/rtl/bmp_pixel_array_decoder_core.sv -----
// An accepted data word passes the job queue, the single palette read stage of
// the back end and the result queue before its first result shows. Results issue
// one per cycle while the result queue has room, up to 8 per word in 1-bit mode.
// A 4-entry job queue lets the front accept words while the back expands.
// Reset (rst, synchronous) restores register defaults and clears parse state;
// palette contents are undefined until written.
module bmp_pixel_array_decoder_core #(
  parameter int PALETTE_DEPTH = bpd_pkg::PALETTE_DEPTH_DEF,
  parameter int COORD_BITS    = bpd_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  palette_index,
  input  logic [7:0]  palette_red,
  input  logic [7:0]  palette_green,
  input  logic [7:0]  palette_blue,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  second_red,
  output logic [7:0]  second_green,
  output logic [7:0]  second_blue,
  output logic [7:0]  repeat_count,
  output logic        alternating,
  output logic        row_end,
  output logic        image_end,
  output logic        error_flag,
  output logic        last_for_byte
);
  localparam int JW = $bits(bpd_pkg::bpd_job_t);
  localparam int RW = $bits(bpd_pkg::bpd_res_t);

  logic              take;
  logic              job_push;
  bpd_pkg::bpd_job_t job_in;
  bpd_pkg::bpd_job_t job_head;
  logic              job_pop;
  logic              job_empty;
  logic [$clog2(bpd_pkg::JOB_DEPTH+1)-1:0] job_count;
  logic              res_push;
  bpd_pkg::bpd_res_t res_in;
  bpd_pkg::bpd_res_t res_head;
  logic              res_full;
  logic [$clog2(bpd_pkg::RES_DEPTH+1)-1:0] res_count;

  assign take = push && !full;

  bpd_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .take         (take),
    .action       (action),
    .data_byte    (data_byte),
    .palette_index(palette_index),
    .palette_red  (palette_red),
    .palette_green(palette_green),
    .palette_blue (palette_blue),
    .job_push     (job_push),
    .job          (job_in)
  );

  bpd_fifo #(
    .W    (JW),
    .DEPTH(bpd_pkg::JOB_DEPTH)
  ) u_job_q (
    .clk  (clk),
    .rst  (rst),
    .wr   (job_push),
    .wdata(job_in),
    .rd   (job_pop),
    .rdata(job_head),
    .count(job_count),
    .full (full),
    .empty(job_empty)
  );

  bpd_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(!job_empty),
    .job      (job_head),
    .job_pop  (job_pop),
    .res_count(res_count),
    .res_push (res_push),
    .res      (res_in)
  );

  bpd_fifo #(
    .W    (RW),
    .DEPTH(bpd_pkg::RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .wr   (res_push),
    .wdata(res_in),
    .rd   (pop && !empty),
    .rdata(res_head),
    .count(res_count),
    .full (res_full),
    .empty(empty)
  );

  // result word onto the ports
  always_comb begin
    red           = res_head.red;
    green         = res_head.green;
    blue          = res_head.blue;
    second_red    = res_head.second_red;
    second_green  = res_head.second_green;
    second_blue   = res_head.second_blue;
    repeat_count  = res_head.repeat_count;
    alternating   = res_head.alternating;
    row_end       = res_head.row_end;
    image_end     = res_head.image_end;
    error_flag    = res_head.error_flag;
    last_for_byte = res_head.last_for_byte | (job_count == '1 && 1'b0);
  end
endmodule

// ----- hw/rtl/bpd_fifo.sv -----
// Small synchronous FIFO used for the job queue and the result queue.
module bpd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr,
  input  logic [W-1:0]               wdata,
  input  logic                       rd,
  output logic [W-1:0]               rdata,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       full,
  output logic                       empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [$clog2(DEPTH+1)-1:0] DEPTH_C = ($clog2(DEPTH+1))'(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;

  assign full  = (count == DEPTH_C);
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == LAST) ? '0 : wptr + AW'(1);
      end
      if (rd) begin
        rptr <= (rptr == LAST) ? '0 : rptr + AW'(1);
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end
endmodule

// ----- hw/rtl/bpd_front.sv -----
// Front end: config registers, parse state, at most one job per accepted word.
module bpd_front #(
  parameter int PALETTE_DEPTH = bpd_pkg::PALETTE_DEPTH_DEF,
  parameter int COORD_BITS    = bpd_pkg::COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              take,
  input  logic [1:0]        action,
  input  logic [7:0]        data_byte,
  input  logic [7:0]        palette_index,
  input  logic [7:0]        palette_red,
  input  logic [7:0]        palette_green,
  input  logic [7:0]        palette_blue,
  output logic              job_push,
  output bpd_pkg::bpd_job_t job
);
  localparam logic [8:0] PD9 = 9'(PALETTE_DEPTH);

  logic [2:0]  mode;
  logic [15:0] width;
  logic [15:0] height;
  logic [8:0]  pcount;

  bpd_pkg::bpd_phase_t phase, phase_next;
  logic [COORD_BITS-1:0] col, col_next;
  logic [COORD_BITS-1:0] row, row_next;
  logic [1:0]  rbc, rbc_next;
  logic [15:0] gath, gath_next;
  logic [7:0]  runl, runl_next;
  logic [7:0]  absl, absl_next;
  logic        err_held, err_held_next;
  logic        done, done_next;

  logic [COORD_BITS-1:0] row_inc;
  logic                  row_last;

  function automatic logic bad_idx(input logic [7:0] i, input logic [8:0] cnt);
    return (9'(i) >= cnt) || (9'(i) >= PD9);
  endfunction

  assign row_inc  = row + COORD_BITS'(1);
  assign row_last = 17'(row_inc) >= 17'(height);

  // per-word decode
  always_comb begin
    logic                  four;
    logic [7:0]            hi;
    logic [7:0]            lo;
    logic                  pair;
    logic [7:0]            a1;
    logic [COORD_BITS-1:0] c1;
    logic [8:0]            runl_p1;
    logic                  odd;
    logic                  ended;
    logic [16:0]           rem;
    logic [3:0]            cnt;
    logic [3:0]            n;
    logic                  anybad;
    logic [3:0]            badpos;
    logic [7:0]            idx_p;
    logic                  fail;

    phase_next    = phase;
    col_next      = col;
    row_next      = row;
    rbc_next      = rbc;
    gath_next     = gath;
    runl_next     = runl;
    absl_next     = absl;
    err_held_next = err_held;
    done_next     = done;
    job           = '0;
    four          = (mode == bpd_pkg::MODE_RLE4);
    hi            = four ? {4'b0, data_byte[7:4]} : data_byte;
    lo            = {4'b0, data_byte[3:0]};
    pair          = four && (runl >= 8'd2);
    a1            = absl;
    c1            = col;
    runl_p1       = 9'(runl) + 9'd1;
    odd           = four ? runl_p1[1] : runl[0];
    ended         = 1'b0;
    rem           = 17'(width) - 17'(col);
    cnt           = (mode == bpd_pkg::MODE_RGB1) ? 4'd8 : 4'd2;
    n             = (rem < 17'(cnt)) ? rem[3:0] : cnt;
    anybad        = 1'b0;
    badpos        = '0;
    idx_p         = '0;
    fail          = 1'b0;

    if (take) begin
      priority if (action == bpd_pkg::ACT_PAL) begin
        job.pal      = 1'b1;
        job.byte_val = palette_index;
        job.color    = {palette_red, palette_green, palette_blue};
      end else if (action == bpd_pkg::ACT_NEW) begin
        phase_next    = bpd_pkg::PH_FIRST;
        col_next      = '0;
        row_next      = '0;
        rbc_next      = '0;
        gath_next     = '0;
        runl_next     = '0;
        absl_next     = '0;
        err_held_next = 1'b0;
        done_next     = 1'b0;
      end else if (action == bpd_pkg::ACT_DATA && !done) begin
        job.byte_val = data_byte;
        if (err_held) begin
          job.err = 1'b1;
        end else if (mode > bpd_pkg::MODE_RLE8 || width == '0 || height == '0) begin
          fail = 1'b1;
        end else if (mode >= bpd_pkg::MODE_RLE4) begin
          // run-length streams
          unique case (phase)
            bpd_pkg::PH_RUNVAL: begin
              phase_next = bpd_pkg::PH_FIRST;
              if (bad_idx(hi, pcount) || (pair && bad_idx(lo, pcount))) begin
                fail = 1'b1;
              end else if (17'(col) + 17'(runl) > 17'(width)) begin
                fail = 1'b1;
              end else begin
                col_next = col + COORD_BITS'(runl);
                job.run  = 1'b1;
                job.idx1 = hi;
                job.idx2 = lo;
                job.use2 = pair;
                job.rep  = runl;
                job.alt  = pair;
              end
            end
            bpd_pkg::PH_ESCAPE: begin
              phase_next = bpd_pkg::PH_FIRST;
              if (data_byte == 8'd0 || data_byte == 8'd1) begin
                col_next  = '0;
                row_next  = row_inc;
                done_next = row_last || (data_byte == 8'd1);
                job.run   = 1'b1;
                job.mark  = 1'b1;
                job.re    = 1'b1;
                job.ie    = row_last || (data_byte == 8'd1);
              end else if (data_byte == 8'd2) begin
                fail = 1'b1;
              end else begin
                runl_next  = data_byte;
                absl_next  = data_byte;
                phase_next = bpd_pkg::PH_ABS;
              end
            end
            bpd_pkg::PH_ABS: begin
              job.bits = four ? bpd_pkg::BITS_4 : bpd_pkg::BITS_8;
              if (absl != '0) begin
                if (bad_idx(hi, pcount) || 17'(col) >= 17'(width)) begin
                  fail = 1'b1;
                end else begin
                  job.npix = 4'd1;
                  a1 = absl - 8'd1;
                  c1 = col + COORD_BITS'(1);
                  if (four && a1 != '0) begin
                    if (bad_idx(lo, pcount) || 17'(c1) >= 17'(width)) begin
                      fail = 1'b1;
                    end else begin
                      job.npix = 4'd2;
                      a1 = a1 - 8'd1;
                      c1 = c1 + COORD_BITS'(1);
                    end
                  end
                end
              end
              absl_next = a1;
              col_next  = c1;
              if (a1 == '0 && !fail) begin
                phase_next = odd ? bpd_pkg::PH_ABSPAD : bpd_pkg::PH_FIRST;
              end
            end
            bpd_pkg::PH_ABSPAD: begin
              phase_next = bpd_pkg::PH_FIRST;
            end
            default: begin
              if (data_byte == 8'd0) begin
                phase_next = bpd_pkg::PH_ESCAPE;
              end else begin
                runl_next  = data_byte;
                phase_next = bpd_pkg::PH_RUNVAL;
              end
            end
          endcase
        end else begin
          // uncompressed rows
          rbc_next = rbc + 2'd1;
          if (phase == bpd_pkg::PH_PAD) begin
            if (rbc_next == 2'd0) begin
              phase_next = bpd_pkg::PH_FIRST;
            end
          end else if (17'(col) >= 17'(width)) begin
            fail = 1'b1;
          end else if (mode == bpd_pkg::MODE_RGB1 || mode == bpd_pkg::MODE_RGB4) begin
            phase_next = bpd_pkg::PH_FIRST;
            job.bits   = (mode == bpd_pkg::MODE_RGB1) ? bpd_pkg::BITS_1 : bpd_pkg::BITS_4;
            for (int p = 7; p >= 0; p--) begin
              if (mode == bpd_pkg::MODE_RGB1) begin
                idx_p = {7'b0, data_byte[7-p]};
              end else begin
                idx_p = (p == 0) ? {4'b0, data_byte[7:4]} : lo;
              end
              if (4'(p) < n && bad_idx(idx_p, pcount)) begin
                anybad = 1'b1;
                badpos = 4'(p);
              end
            end
            if (anybad) begin
              job.npix = badpos;
              fail     = 1'b1;
            end else begin
              job.npix = n;
              col_next = col + COORD_BITS'(n);
              ended    = (17'(n) == rem);
            end
          end else if (mode == bpd_pkg::MODE_RGB8) begin
            phase_next = bpd_pkg::PH_FIRST;
            if (bad_idx(data_byte, pcount)) begin
              fail = 1'b1;
            end else begin
              job.npix = 4'd1;
              job.bits = bpd_pkg::BITS_8;
              c1       = col + COORD_BITS'(1);
              col_next = c1;
              ended    = 17'(c1) >= 17'(width);
            end
          end else if (phase == bpd_pkg::PH_GREEN) begin
            gath_next  = {data_byte, gath[7:0]};
            phase_next = bpd_pkg::PH_RED;
          end else if (phase == bpd_pkg::PH_RED) begin
            phase_next = bpd_pkg::PH_FIRST;
            job.npix   = 4'd1;
            job.direct = 1'b1;
            job.color  = {data_byte, gath};
            c1         = col + COORD_BITS'(1);
            col_next   = c1;
            ended      = 17'(c1) >= 17'(width);
          end else begin
            gath_next  = {8'b0, data_byte};
            phase_next = bpd_pkg::PH_GREEN;
          end
          // row finished by the last pixel of this word
          if (ended) begin
            col_next  = '0;
            row_next  = row_inc;
            done_next = row_last;
            job.re    = 1'b1;
            job.ie    = row_last;
            if (!row_last && rbc_next != 2'd0) begin
              phase_next = bpd_pkg::PH_PAD;
            end
          end
        end
        if (fail) begin
          job.err       = 1'b1;
          err_held_next = 1'b1;
        end
      end else begin
        job = '0;
      end
    end
  end

  assign job_push = job.pal || job.err || job.run || (job.npix != '0);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= bpd_pkg::MODE_RGB24;
      width  <= 16'd1;
      height <= 16'd1;
      pcount <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bpd_pkg::REG_MODE:   mode   <= cfg_data[2:0];
        bpd_pkg::REG_WIDTH:  width  <= cfg_data;
        bpd_pkg::REG_HEIGHT: height <= cfg_data;
        bpd_pkg::REG_PCOUNT: pcount <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= bpd_pkg::PH_FIRST;
      col      <= '0;
      row      <= '0;
      rbc      <= '0;
      gath     <= '0;
      runl     <= '0;
      absl     <= '0;
      err_held <= 1'b0;
      done     <= 1'b0;
    end else begin
      phase    <= phase_next;
      col      <= col_next;
      row      <= row_next;
      rbc      <= rbc_next;
      gath     <= gath_next;
      runl     <= runl_next;
      absl     <= absl_next;
      err_held <= err_held_next;
      done     <= done_next;
    end
  end
endmodule

// ----- hw/rtl/bpd_back.sv -----
// Back end: palette RAM; expands jobs to results, one per cycle with room.
module bpd_back #(
  parameter int PALETTE_DEPTH = bpd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      job_valid,
  input  bpd_pkg::bpd_job_t                         job,
  output logic                                      job_pop,
  input  logic [$clog2(bpd_pkg::RES_DEPTH+1)-1:0]   res_count,
  output logic                                      res_push,
  output bpd_pkg::bpd_res_t                         res
);
  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(bpd_pkg::RES_DEPTH + 1);
  localparam logic [8:0] PD9 = 9'(PALETTE_DEPTH);

  logic [23:0] mem [PALETTE_DEPTH];
  logic [23:0] rd1;
  logic [23:0] rd2;

  logic [3:0] pos;
  logic [3:0] total;
  logic       room;
  logic       issue;
  logic       last;
  logic       is_pix;
  logic       is_run;
  logic [7:0] pidx;
  logic [7:0] addr1;

  // second stage: result waiting for memory data
  logic              s_valid;
  bpd_pkg::bpd_res_t s_res;
  logic              s_use1;
  logic              s_direct;
  logic [23:0]       s_dcolor;
  logic              s_use2;
  bpd_pkg::bpd_res_t meta;

  assign total  = job.npix + 4'(job.run) + 4'(job.err);
  assign room   = (CW'(res_count) + CW'(s_valid)) < CW'(bpd_pkg::RES_DEPTH);
  assign issue  = job_valid && !job.pal && room;
  assign last   = (pos == total - 4'd1);
  assign is_pix = (pos < job.npix);
  assign is_run = !is_pix && job.run;
  assign job_pop = job_valid && (job.pal || (issue && last));

  // pixel index cut from the stored byte
  always_comb begin
    unique case (job.bits)
      bpd_pkg::BITS_1: pidx = {7'b0, job.byte_val[3'd7 - pos[2:0]]};
      bpd_pkg::BITS_4: pidx = (pos == 4'd0) ? {4'b0, job.byte_val[7:4]}
                                            : {4'b0, job.byte_val[3:0]};
      default:         pidx = job.byte_val;
    endcase
  end

  assign addr1 = is_pix ? pidx : job.idx1;

  // result fields other than colors
  always_comb begin
    meta               = '0;
    meta.repeat_count  = is_pix ? 8'd1 : (is_run ? job.rep : 8'd0);
    meta.alternating   = is_run && job.alt;
    meta.row_end       = job.re && last;
    meta.image_end     = job.ie && last;
    meta.error_flag    = !is_pix && !is_run;
    meta.last_for_byte = last;
  end

  // issue position within the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      s_valid <= 1'b0;
    end else begin
      s_valid <= issue;
      if (issue) begin
        pos <= last ? 4'd0 : pos + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s_res    <= meta;
      s_use1   <= (is_pix && !job.direct) || (is_run && !job.mark);
      s_direct <= is_pix && job.direct;
      s_dcolor <= job.color;
      s_use2   <= is_run && job.use2;
    end
  end

  // palette memory: one write port, two registered reads
  always_ff @(posedge clk) begin
    if (job_valid && job.pal && (9'(job.byte_val) < PD9)) begin
      mem[job.byte_val[AW-1:0]] <= job.color;
    end
    rd1 <= mem[addr1[AW-1:0]];
    rd2 <= mem[job.idx2[AW-1:0]];
  end

  // color merge into the result word
  always_comb begin
    logic [23:0] c1;
    logic [23:0] c2;
    c1 = s_direct ? s_dcolor : (s_use1 ? rd1 : 24'd0);
    c2 = s_use2 ? rd2 : 24'd0;
    res              = s_res;
    res.red          = c1[23:16];
    res.green        = c1[15:8];
    res.blue         = c1[7:0];
    res.second_red   = c2[23:16];
    res.second_green = c2[15:8];
    res.second_blue  = c2[7:0];
  end

  assign res_push = s_valid;
endmodule

// ----- hw/rtl/bpd_checker.sv -----
// Port-level checker for the decoder, bound to the top level.
`include "bmp_pixel_array_decoder_core_macros.svh"

module bpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic [7:0] repeat_count,
  input logic       row_end,
  input logic       image_end,
  input logic       error_flag,
  input logic       last_for_byte
);
  // the result queue comes out of reset empty
  `BPD_ASSERT_NEXT(a_reset_empty, rst, empty)
  // an error word carries nothing else and ends its input word
  `BPD_ASSERT_IMPLY(a_err_bare, !empty && error_flag, repeat_count == 8'd0 && !row_end && !image_end && last_for_byte)
  // image end only ever closes a row
  `BPD_ASSERT_IMPLY(a_img_row, !empty && image_end, row_end)
  // a zero-length word that is not an error is a row marker
  `BPD_ASSERT_IMPLY(a_marker, !empty && !error_flag && repeat_count == 8'd0, row_end && last_for_byte)
endmodule

bind bmp_pixel_array_decoder_core bpd_checker u_bpd_checker (
  .clk          (clk),
  .rst          (rst),
  .empty        (empty),
  .repeat_count (repeat_count),
  .row_end      (row_end),
  .image_end    (image_end),
  .error_flag   (error_flag),
  .last_for_byte(last_for_byte)
);
